// File: src/ppu_cri_pkg.sv
// shared types, codes and constants of the picture-unit cpu register interface
`default_nettype none

package ppu_cri_pkg;

  // default sprite memory depth
  localparam int unsigned OamDepthDefault = 256;

  // operation codes
  localparam logic [2:0] OpRead   = 3'd0;
  localparam logic [2:0] OpWrite  = 3'd1;
  localparam logic [2:0] OpPeek   = 3'd2;
  localparam logic [2:0] OpSetSt  = 3'd3;
  localparam logic [2:0] OpClrSt  = 3'd4;
  localparam logic [2:0] OpDma    = 3'd5;

  // register indexes
  localparam logic [2:0] RegCtrl   = 3'd0;
  localparam logic [2:0] RegMask   = 3'd1;
  localparam logic [2:0] RegStatus = 3'd2;
  localparam logic [2:0] RegOamAddr = 3'd3;
  localparam logic [2:0] RegOamData = 3'd4;
  localparam logic [2:0] RegScroll = 3'd5;
  localparam logic [2:0] RegAddr   = 3'd6;
  localparam logic [2:0] RegData   = 3'd7;

  // start of palette space, high byte of the video address
  localparam logic [5:0] PaletteHi = 6'h3F;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] register_index;
    logic [7:0] write_data;
    logic [7:0] oam_index;
    logic [7:0] mem_data;
    logic [7:0] mem_data_shadow;
    logic [2:0] status_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        vram_write_enable;
    logic [13:0] vram_write_address;
    logic [7:0]  vram_write_data;
    logic [13:0] current_address;
    logic [15:0] temp_address;
    logic [2:0]  fine_scroll_x;
    logic        nmi_request;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/ppu_cri_stream_if.sv
// valid/ready channel carrying one payload item per transfer
`default_nettype none

interface ppu_cri_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/ppu_cri_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ppu_cri_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/ppu_cpu_register_interface_core.sv
// top level of the picture-unit cpu register interface
//
//  channel  | dir | payload     | transfer when
//  ---------+-----+-------------+--------------------------
//  in_if    | in  | in_item_t   | in_if.valid & in_if.ready
//  out_if   | out | out_item_t  | out_if.valid & out_if.ready
//
// one item per clock barring output stalls; results appear the cycle after intake
// all architectural registers update at the input transfer edge; sprite memory is read and
// written in that same edge, so a sprite data read lands in the output register slot
// input ready follows the output slot: free, or being emptied in the same cycle
// reset clears the state registers and all sprite memory valid bits at once, no sweep
`default_nettype none

module ppu_cpu_register_interface_core
  import ppu_cri_pkg::*;
#(
  parameter int unsigned OAM_DEPTH = OamDepthDefault
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  ppu_cri_stream_if.sink     in_if,
  ppu_cri_stream_if.source   out_if
);

  localparam int unsigned AW        = $clog2(OAM_DEPTH);
  // a byte index needs at most this many subtractions to fall below the depth
  localparam int unsigned WrapSteps = 255 / OAM_DEPTH;
  localparam logic [8:0]  DepthW    = 9'(OAM_DEPTH);

  // byte index taken modulo the sprite memory depth
  function automatic logic [AW-1:0] oam_wrap(logic [7:0] a);
    logic [8:0] t;
    t = {1'b0, a};
    for (int unsigned i = 0; i < WrapSteps; i++) begin
      if (t >= DepthW) begin
        t = t - DepthW;
      end
    end
    return t[AW-1:0];
  endfunction

  // architectural state
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [2:0]  flags_q, flags_d;
  logic [7:0]  oam_addr_q, oam_addr_d;
  logic [7:0]  latch_q, latch_d;
  logic        latch_oam_q, latch_oam_d;   // latch still sits in the ram read port
  logic [7:0]  rbuf_q, rbuf_d;
  logic [15:0] temp_q, temp_d;
  logic [13:0] cur_q, cur_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic        toggle_q, toggle_d;
  logic [OAM_DEPTH-1:0] oam_vld_q;
  logic        rd_vld_q;

  // output slot
  logic        out_vld_q;
  logic        rd_oam_q, rd_oam_d;
  out_item_t   out_q, out_d;

  // sprite memory port signals
  logic          oam_we, oam_re;
  logic [AW-1:0] oam_waddr, oam_raddr;
  logic [7:0]    oam_wdata, oam_rdata, oam_eff, latch_eff;

  in_item_t   it;
  logic       xfer_in;
  logic [13:0] cur_step;

  assign it        = in_if.payload;
  assign in_if.ready = !out_vld_q || out_if.ready;
  assign xfer_in   = in_if.valid && in_if.ready;

  // an entry never written reads as zero
  assign oam_eff   = rd_vld_q ? oam_rdata : 8'h00;
  // bus latch forwarded from the last sprite data read when that one is pending
  assign latch_eff = latch_oam_q ? oam_eff : latch_q;

  assign cur_step  = cur_q + (ctrl_q[2] ? 14'd32 : 14'd1);
  assign oam_raddr = oam_wrap(oam_addr_q);

  ppu_cri_ram #(
    .WIDTH (8),
    .DEPTH (OAM_DEPTH)
  ) u_oam (
    .clk_i   (clk_i),
    .we_i    (oam_we),
    .waddr_i (oam_waddr),
    .wdata_i (oam_wdata),
    .re_i    (oam_re),
    .raddr_i (oam_raddr),
    .rdata_o (oam_rdata)
  );

  // next state and result for the item at the input
  always_comb begin
    ctrl_d      = ctrl_q;
    mask_d      = mask_q;
    flags_d     = flags_q;
    oam_addr_d  = oam_addr_q;
    latch_d     = latch_eff;
    latch_oam_d = 1'b0;
    rbuf_d      = rbuf_q;
    temp_d      = temp_q;
    cur_d       = cur_q;
    fine_x_d    = fine_x_q;
    toggle_d    = toggle_q;
    rd_oam_d    = 1'b0;
    oam_we      = 1'b0;
    oam_waddr   = oam_raddr;
    oam_wdata   = it.write_data;
    oam_re      = 1'b0;
    out_d       = '0;

    case (it.operation)
      OpRead: begin
        case (it.register_index)
          RegCtrl: begin
            out_d.read_data = ctrl_q;
          end
          RegMask: begin
            out_d.read_data = mask_q;
          end
          RegStatus: begin
            // flags on top, open bus below; clears vblank and the toggle
            out_d.read_data = {flags_q, latch_eff[4:0]};
            flags_d[2]      = 1'b0;
            toggle_d        = 1'b0;
          end
          RegOamAddr: begin
            out_d.read_data = oam_addr_q;
          end
          RegOamData: begin
            oam_re      = xfer_in;
            rd_oam_d    = 1'b1;
            latch_oam_d = 1'b1;
          end
          RegScroll, RegAddr: begin
            out_d.read_data = latch_eff;
          end
          default: begin
            // data port: palette reads bypass the buffer
            if (cur_q[13:8] == PaletteHi) begin
              out_d.read_data = it.mem_data;
              rbuf_d          = it.mem_data_shadow;
            end else begin
              out_d.read_data = rbuf_q;
              rbuf_d          = it.mem_data;
            end
            cur_d = cur_step;
          end
        endcase
        if (!(it.register_index inside {RegScroll, RegAddr, RegOamData})) begin
          latch_d = out_d.read_data;
        end
      end
      OpWrite: begin
        latch_d = it.write_data;
        case (it.register_index)
          RegCtrl: begin
            ctrl_d        = it.write_data;
            temp_d[11:10] = it.write_data[1:0];
          end
          RegMask: begin
            mask_d = it.write_data;
          end
          RegStatus: begin
          end
          RegOamAddr: begin
            oam_addr_d = it.write_data;
          end
          RegOamData: begin
            oam_we     = xfer_in;
            oam_addr_d = oam_addr_q + 8'd1;
          end
          RegScroll: begin
            if (!toggle_q) begin
              fine_x_d    = it.write_data[2:0];
              temp_d[4:0] = it.write_data[7:3];
              toggle_d    = 1'b1;
            end else begin
              temp_d[14:12] = it.write_data[2:0];
              temp_d[9:5]   = it.write_data[7:3];
              toggle_d      = 1'b0;
            end
          end
          RegAddr: begin
            if (!toggle_q) begin
              temp_d[15:8] = it.write_data;
              toggle_d     = 1'b1;
            end else begin
              temp_d   = {2'b00, temp_q[13:8], it.write_data};
              cur_d    = {temp_q[13:8], it.write_data};
              toggle_d = 1'b0;
            end
          end
          default: begin
            out_d.vram_write_enable  = 1'b1;
            out_d.vram_write_address = cur_q;
            out_d.vram_write_data    = it.write_data;
            cur_d                    = cur_step;
          end
        endcase
      end
      OpPeek: begin
        case (it.register_index)
          RegCtrl:   out_d.read_data = ctrl_q;
          RegMask:   out_d.read_data = mask_q;
          RegStatus: out_d.read_data = {flags_q, 5'b00000};
          default:   out_d.read_data = 8'h00;
        endcase
      end
      OpSetSt: begin
        flags_d           = flags_q | it.status_bits;
        out_d.nmi_request = it.status_bits[2] && ctrl_q[7];
      end
      OpClrSt: begin
        flags_d = flags_q & ~it.status_bits;
      end
      OpDma: begin
        oam_we    = xfer_in;
        oam_waddr = oam_wrap(it.oam_index);
      end
      default: begin
      end
    endcase

    out_d.current_address = cur_d;
    out_d.temp_address    = temp_d;
    out_d.fine_scroll_x   = fine_x_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      mask_q      <= '0;
      flags_q     <= '0;
      oam_addr_q  <= '0;
      latch_q     <= '0;
      latch_oam_q <= 1'b0;
      rbuf_q      <= '0;
      temp_q      <= '0;
      cur_q       <= '0;
      fine_x_q    <= '0;
      toggle_q    <= 1'b0;
      oam_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      rd_oam_q    <= 1'b0;
    end else begin
      if (xfer_in) begin
        ctrl_q      <= ctrl_d;
        mask_q      <= mask_d;
        flags_q     <= flags_d;
        oam_addr_q  <= oam_addr_d;
        latch_q     <= latch_d;
        latch_oam_q <= latch_oam_d;
        rbuf_q      <= rbuf_d;
        temp_q      <= temp_d;
        cur_q       <= cur_d;
        fine_x_q    <= fine_x_d;
        toggle_q    <= toggle_d;
        rd_oam_q    <= rd_oam_d;
      end
      if (oam_we) begin
        oam_vld_q[oam_waddr] <= 1'b1;
      end
      // valid bit travels with the ram read data
      if (oam_re) begin
        rd_vld_q <= oam_vld_q[oam_raddr];
      end
      if (xfer_in) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (xfer_in) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_if.payload           = out_q;
    out_if.payload.read_data = rd_oam_q ? oam_eff : out_q.read_data;
  end

  assign out_if.valid = out_vld_q;

endmodule

`default_nettype wire

// File: src/ppu_cri_checker.sv
// port-level checks for the picture-unit cpu register interface, with its bind
`default_nettype none

module ppu_cri_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  read_data_i,
  input wire logic        vram_we_i,
  input wire logic [13:0] vram_addr_i,
  input wire logic [13:0] cur_addr_i,
  input wire logic        nmi_i
);

  // every accepted item shows up at the output the cycle after
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result");

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // data port writes step the current address by one or by a row
  a_vram_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && vram_we_i |->
      (cur_addr_i == 14'(vram_addr_i + 14'd1)) || (cur_addr_i == 14'(vram_addr_i + 14'd32)))
    else $error("current address not stepped after data port write");

  // video writes and nmi events return no read data
  a_quiet_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (vram_we_i || nmi_i) |-> (read_data_i == 8'h00) && !(vram_we_i && nmi_i))
    else $error("read data or nmi on a write result");

endmodule

bind ppu_cpu_register_interface_core ppu_cri_checker u_ppu_cri_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .read_data_i (out_if.payload.read_data),
  .vram_we_i   (out_if.payload.vram_write_enable),
  .vram_addr_i (out_if.payload.vram_write_address),
  .cur_addr_i  (out_if.payload.current_address),
  .nmi_i       (out_if.payload.nmi_request)
);

`default_nettype wire

// File: verif/ppu_cpu_register_interface_core_tb.sv
// testbench of the picture-unit cpu register interface: register tracker, stimulus and checks
`timescale 1ns / 100ps

import ppu_cri_pkg::*;

// keeps its own copy of the register file, works out each reply and checks the block's
class cpu_reg_tracker;
  localparam int Slots = OamDepthDefault;

  logic [7:0]  ctrl;
  logic [7:0]  mask;
  logic [2:0]  flags;
  logic [7:0]  oam_ptr;
  logic [7:0]  oam [Slots];
  logic [7:0]  latch;
  logic [7:0]  rbuf;
  logic [15:0] tmp;
  logic [13:0] vaddr;
  logic [2:0]  fx;
  logic        toggle;

  out_item_t   pending_replies [$];
  int unsigned mismatches;
  int unsigned replies_seen;
  int unsigned nmi_seen;
  int unsigned vram_writes;

  function new();
    ctrl = '0;
    mask = '0;
    flags = '0;
    oam_ptr = '0;
    foreach (oam[i]) oam[i] = '0;
    latch = '0;
    rbuf = '0;
    tmp = '0;
    vaddr = '0;
    fx = '0;
    toggle = 1'b0;
    mismatches = 0;
    replies_seen = 0;
    nmi_seen = 0;
    vram_writes = 0;
  endfunction

  // data port accesses step by one, or by a row of 32 with control bit2
  function void bump_vaddr();
    vaddr = vaddr + (ctrl[2] ? 14'd32 : 14'd1);
  endfunction

  function void note_input(in_item_t it);
    out_item_t r;
    logic [7:0] d;
    r = '0;
    d = it.write_data;
    case (it.operation)
      OpRead: begin
        case (it.register_index)
          RegCtrl:    r.read_data = ctrl;
          RegMask:    r.read_data = mask;
          RegStatus: begin
            r.read_data = {flags, latch[4:0]};
            flags[2] = 1'b0;
            toggle = 1'b0;
          end
          RegOamAddr: r.read_data = oam_ptr;
          RegOamData: r.read_data = oam[oam_ptr % Slots];
          RegScroll, RegAddr: r.read_data = latch;
          default: begin
            // palette reads bypass the buffer, which takes the shadow byte
            if (vaddr[13:8] == PaletteHi) begin
              r.read_data = it.mem_data;
              rbuf = it.mem_data_shadow;
            end else begin
              r.read_data = rbuf;
              rbuf = it.mem_data;
            end
            bump_vaddr();
          end
        endcase
        latch = r.read_data;
      end
      OpWrite: begin
        latch = d;
        case (it.register_index)
          RegCtrl: begin
            ctrl = d;
            tmp[11:10] = d[1:0];
          end
          RegMask:    mask = d;
          RegStatus:  ;
          RegOamAddr: oam_ptr = d;
          RegOamData: begin
            oam[oam_ptr % Slots] = d;
            oam_ptr = oam_ptr + 8'd1;
          end
          RegScroll: begin
            if (!toggle) begin
              fx = d[2:0];
              tmp[4:0] = d[7:3];
            end else begin
              tmp[14:12] = d[2:0];
              tmp[9:5] = d[7:3];
            end
            toggle = ~toggle;
          end
          RegAddr: begin
            if (!toggle) begin
              tmp[15:8] = d;
            end else begin
              tmp[15:14] = 2'b00;
              tmp[7:0] = d;
              vaddr = tmp[13:0];
            end
            toggle = ~toggle;
          end
          default: begin
            r.vram_write_enable = 1'b1;
            r.vram_write_address = vaddr;
            r.vram_write_data = d;
            bump_vaddr();
          end
        endcase
      end
      OpPeek: begin
        case (it.register_index)
          RegCtrl:   r.read_data = ctrl;
          RegMask:   r.read_data = mask;
          RegStatus: r.read_data = {flags, 5'b00000};
          default:   r.read_data = '0;
        endcase
      end
      OpSetSt: begin
        flags = flags | it.status_bits;
        r.nmi_request = it.status_bits[2] & ctrl[7];
      end
      OpClrSt: flags = flags & ~it.status_bits;
      OpDma:   oam[it.oam_index % Slots] = d;
      default: ;
    endcase
    r.current_address = vaddr;
    r.temp_address = tmp;
    r.fine_scroll_x = fx;
    pending_replies.insert(pending_replies.size(), r);
  endfunction

  function void match(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending_replies.size() == 0) begin
      $error("reply with no expectation waiting");
      mismatches++;
      return;
    end
    want = pending_replies.pop_front();
    replies_seen++;
    if (want.nmi_request) nmi_seen++;
    if (want.vram_write_enable) vram_writes++;
    match("read_data", want.read_data, got.read_data);
    match("vram_write_enable", want.vram_write_enable, got.vram_write_enable);
    match("vram_write_address", want.vram_write_address, got.vram_write_address);
    match("vram_write_data", want.vram_write_data, got.vram_write_data);
    match("current_address", want.current_address, got.current_address);
    match("temp_address", want.temp_address, got.temp_address);
    match("fine_scroll_x", want.fine_scroll_x, got.fine_scroll_x);
    match("nmi_request", want.nmi_request, got.nmi_request);
  endfunction
endclass

module ppu_cpu_register_interface_core_tb;

  // operation codes the block must ignore
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam int unsigned RandomItems = 1500;
  localparam int unsigned LongHold    = 300;
  // set well above the run time of the slowest correct run
  localparam int unsigned CycleLimit  = 400000;

  logic clk_i;
  logic rst_ni;
  logic long_hold_req;

  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned directed_items;
  int unsigned burst_left;

  cpu_reg_tracker tracker;

  ppu_cri_stream_if #(.T(in_item_t))  cmd_ch ();
  ppu_cri_stream_if #(.T(out_item_t)) reply_ch ();

  ppu_cpu_register_interface_core #(
    .OAM_DEPTH(OamDepthDefault)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_ch),
    .out_if (reply_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("ppu_cpu_register_interface_core verification failed");
      $finish;
    end
  end

  // transfer monitor: replies are checked before the command of the same edge is noted,
  // so a spurious reply can never be matched against a fresh expectation
  always @(posedge clk_i) begin
    if (reply_ch.valid && reply_ch.ready) tracker.check_result(reply_ch.payload);
    if (cmd_ch.valid && cmd_ch.ready) tracker.note_input(cmd_ch.payload);
  end

  // reply side: a randomly redrawn stall mode; a long hold-off on request
  initial begin : reply_sink
    int unsigned tick;
    int unsigned mode;
    tick = 0;
    mode = 0;
    reply_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (long_hold_req) begin
        // hold off long enough that the output slot fills and input ready drops
        long_hold_req <= 1'b0;
        reply_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        if (tick % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       reply_ch.ready <= 1'b1;
          1:       reply_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       reply_ch.ready <= (tick % 3 == 0);
          default: reply_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // every field random so that all bits toggle; callers override what matters
  function automatic in_item_t random_item();
    in_item_t it;
    it.operation       = 3'($urandom_range(0, 7));
    it.register_index  = 3'($urandom_range(0, 7));
    it.write_data      = 8'($urandom_range(0, 255));
    it.oam_index       = 8'($urandom_range(0, 255));
    it.mem_data        = 8'($urandom_range(0, 255));
    it.mem_data_shadow = 8'($urandom_range(0, 255));
    it.status_bits     = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic [2:0] sel, logic [7:0] d);
    in_item_t it;
    it = random_item();
    it.operation = op;
    it.register_index = sel;
    it.write_data = d;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // one command transfer, then the burst/gap pacing of the command side
  task automatic offer(input in_item_t it);
    int unsigned idle;
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= it;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
      if (idle != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end
  endtask

  // stop offering and wait for every outstanding reply
  task automatic drain_replies();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_pass();
    in_item_t it;
    offer(mk(OpWrite, RegCtrl, 8'hFF));      // nmi enable, row step, nametable bits
    offer(mk(OpWrite, RegMask, 8'hFF));
    it = mk(OpSetSt, RegCtrl, rand_byte());
    it.status_bits = 3'b111;
    offer(it);                               // vblank with nmi enabled
    offer(mk(OpPeek, RegStatus, rand_byte()));
    offer(mk(OpPeek, RegCtrl, rand_byte()));
    offer(mk(OpPeek, RegData, rand_byte()));
    offer(mk(OpRead, RegStatus, rand_byte()));  // clears vblank and the toggle
    offer(mk(OpWrite, RegStatus, 8'hA5));       // latch only
    offer(mk(OpRead, RegScroll, rand_byte()));  // open bus
    offer(mk(OpWrite, RegOamAddr, 8'hFF));
    offer(mk(OpWrite, RegOamData, 8'h5A));      // sprite address wraps to zero
    offer(mk(OpRead, RegOamAddr, rand_byte()));
    offer(mk(OpRead, RegOamData, rand_byte()));
    it = mk(OpDma, RegCtrl, 8'h00);
    it.oam_index = 8'hFF;
    offer(it);
    offer(mk(OpWrite, RegCtrl, 8'h00));
    offer(mk(OpWrite, RegScroll, 8'hFF));
    offer(mk(OpWrite, RegScroll, 8'h00));
    offer(mk(OpWrite, RegAddr, 8'hFF));         // top bits cleared on the second write
    offer(mk(OpWrite, RegAddr, 8'hFF));
    offer(mk(OpRead, RegData, rand_byte()));    // palette read, address wraps
    offer(mk(OpWrite, RegData, 8'hFF));
    offer(mk(OpRead, RegData, rand_byte()));    // buffered read
    it = mk(OpClrSt, RegCtrl, rand_byte());
    it.status_bits = 3'b111;
    offer(it);
    offer(mk(OpSpare6, 3'($urandom_range(0, 7)), rand_byte()));
    offer(mk(OpSpare7, 3'($urandom_range(0, 7)), rand_byte()));
  endtask

  // well-formed access patterns with random content, plus noise and broken pairs
  task automatic random_sequence();
    in_item_t it;
    int unsigned n;
    int unsigned base;
    case ($urandom_range(0, 9))
      0, 1: begin
        offer(mk(OpWrite, RegAddr, ($urandom_range(0, 2) == 0) ? 8'h3F : rand_byte()));
        offer(mk(OpWrite, RegAddr, rand_byte()));
        n = $urandom_range(1, 6);
        repeat (n) offer(mk(($urandom_range(0, 1) == 0) ? OpRead : OpWrite, RegData,
                            rand_byte()));
      end
      2: begin
        offer(mk(OpWrite, RegScroll, rand_byte()));
        offer(mk(OpWrite, RegScroll, rand_byte()));
      end
      3: begin
        offer(mk(OpWrite, RegOamAddr, rand_byte()));
        n = $urandom_range(1, 6);
        repeat (n) offer(mk(($urandom_range(0, 2) == 0) ? OpRead : OpWrite, RegOamData,
                            rand_byte()));
        offer(mk(OpRead, RegOamAddr, rand_byte()));
      end
      4: begin
        offer(mk(($urandom_range(0, 2) == 0) ? OpClrSt : OpSetSt, RegCtrl, rand_byte()));
        offer(mk(OpPeek, RegStatus, rand_byte()));
        offer(mk(OpRead, RegStatus, rand_byte()));
      end
      5: begin
        offer(mk(OpWrite, ($urandom_range(0, 1) == 0) ? RegCtrl : RegMask, rand_byte()));
        offer(mk(OpPeek, 3'($urandom_range(0, 7)), rand_byte()));
      end
      6: begin
        n = $urandom_range(1, 8);
        base = $urandom_range(0, 255);
        for (int i = 0; i < n; i++) begin
          it = mk(OpDma, RegCtrl, rand_byte());
          it.oam_index = 8'(base + i);
          offer(it);
        end
      end
      7, 8: offer(random_item());
      default: begin
        // address pair broken by a status read, which resets the toggle
        offer(mk(OpWrite, RegAddr, rand_byte()));
        offer(mk(OpRead, RegStatus, rand_byte()));
        offer(mk(OpWrite, RegAddr, rand_byte()));
      end
    endcase
  endtask

  initial begin : stimulus
    bit first_hold;
    bit second_hold;
    bit paused;
    tracker = new();
    items_sent = 0;
    burst_left = 0;
    first_hold = 1'b0;
    second_hold = 1'b0;
    paused = 1'b0;
    rst_ni <= 1'b0;
    long_hold_req <= 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed_pass();
    directed_items = items_sent;
    drain_replies();

    while (items_sent < directed_items + RandomItems) begin
      // long reply hold-offs while commands keep coming
      if (!first_hold && items_sent >= directed_items + 300) begin
        first_hold = 1'b1;
        long_hold_req <= 1'b1;
        burst_left = 200;
      end
      if (!second_hold && items_sent >= directed_items + 1100) begin
        second_hold = 1'b1;
        long_hold_req <= 1'b1;
        burst_left = 200;
      end
      // one full pause until nothing is in flight
      if (!paused && items_sent >= directed_items + 700) begin
        paused = 1'b1;
        drain_replies();
      end
      random_sequence();
    end

    drain_replies();
    repeat (8) @(posedge clk_i);
    $display("%0d command transfers (%0d directed), %0d replies checked",
             items_sent, directed_items, tracker.replies_seen);
    $display("%0d nmi requests and %0d video writes among them, %0d mismatches",
             tracker.nmi_seen, tracker.vram_writes, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("ppu_cpu_register_interface_core verification clean");
    end else begin
      $display("ppu_cpu_register_interface_core verification failed");
    end
    $finish;
  end

endmodule
